// ===== rtl/core/iprlt_pkg.sv =====
// ----------------------------------------------------------------------------
// iprlt_pkg
// Shared types and codes for the sorted IPv4 range table.
// ----------------------------------------------------------------------------
`default_nettype none

package iprlt_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [31:0] range_last;
    } in_word_t;

    // result word
    typedef struct packed {
        logic is_match;
        logic status;
    } out_word_t;

    // one stored range
    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] end_addr;
    } entry_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture word, open search window over table
        logic rd_mid;      // read entry at search midpoint
        logic srch_step;   // narrow search window using read start
        logic rd_prev;     // read entry just left of search result
        logic rd_shift;    // read entry below shift pointer
        logic wr_shift;    // move read entry up one slot
        logic wr_ins;      // write new range at search result
        logic clear;       // empty the table
        logic finish;      // present the result word
        logic use_match;   // result carries the end compare
        logic full_flag;   // result reports a dropped insert
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic srch_done;   // search window is empty
        logic full;        // no free slot
        logic have_prev;   // search stopped past at least one entry
        logic shift_done;  // shift pointer reached the insert slot
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/iprlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// iprlt_ctrl
// Sequencer for search, shift-insert, lookup and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module iprlt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       op,
    input  wire iprlt_pkg::stat_t stat,
    output iprlt_pkg::cmd_t       cmd,
    output logic                  busy
);
    import iprlt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_LOOK_CMP,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ins_reg, ins_next;
    logic   full_reg, full_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ins_next   = ins_reg;
        full_next  = full_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load  = 1'b1;
                    ins_next  = (op == OP_INSERT);
                    full_next = 1'b0;
                    case (op)
                        OP_INSERT:
                        begin
                            if (stat.full)
                            begin
                                full_next  = 1'b1;
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_SRCH_RD;
                            end
                        end
                        OP_LOOKUP: state_next = ST_SRCH_RD;
                        OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_FIN;
                        end
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (!stat.srch_done)
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
                else if (ins_reg)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else if (stat.have_prev)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_LOOK_CMP;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = ST_SRCH_RD;
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    cmd.wr_ins = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_LOOK_CMP:
            begin
                cmd.finish    = 1'b1;
                cmd.use_match = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FIN:
            begin
                cmd.finish    = 1'b1;
                cmd.full_flag = full_reg;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ins_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ins_reg   <= ins_next;
            full_reg  <= full_next;
        end
    end

    // a result ends the item
    ap_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after result");

    // memory writes only on the insert path
    ap_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_ins || cmd.wr_shift) |-> (ins_reg && !full_reg))
        else $error("table write outside an insert");

endmodule

`default_nettype wire

// ===== rtl/core/iprlt_dp.sv =====
// ----------------------------------------------------------------------------
// iprlt_dp
// Range memory, search window, shift pointer, entry count and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module iprlt_dp #(
    parameter int CAPACITY = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire iprlt_pkg::in_word_t   item,
    input  wire iprlt_pkg::cmd_t       cmd,
    output iprlt_pkg::stat_t           stat,
    output logic                       done,
    output iprlt_pkg::out_word_t       result
);
    import iprlt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    entry_t mem [CAPACITY];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] mid;
    logic [31:0]      key_reg;
    logic [31:0]      last_reg;
    entry_t           rd_reg;
    logic             done_reg;
    out_word_t        result_reg;

    logic [CNT_W-1:0] rd_ptr;
    logic [CNT_W-1:0] wr_ptr;
    logic             rd_en;
    logic             wr_en;
    entry_t           wr_data;

    // search midpoint
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // status toward controller
    assign stat.srch_done  = (lo_reg >= hi_reg);
    assign stat.full       = (count_reg >= CAP_CNT);
    assign stat.have_prev  = (lo_reg != '0);
    assign stat.shift_done = (idx_reg == lo_reg);

    // window, pointer and count update
    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            lo_next  = '0;
            hi_next  = count_reg;
            idx_next = count_reg;
        end
        if (cmd.srch_step)
        begin
            if (rd_reg.start_addr <= key_reg)
                lo_next = mid + ONE_CNT;
            else
                hi_next = mid;
        end
        if (cmd.wr_shift)
            idx_next = idx_reg - ONE_CNT;
        if (cmd.wr_ins)
            count_next = count_reg + ONE_CNT;
        if (cmd.clear)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
            done_reg  <= cmd.finish;
        end
    end

    // captured word and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= item.address;
            last_reg <= item.range_last;
        end
        if (cmd.finish)
        begin
            result_reg.is_match <= cmd.use_match && (key_reg <= rd_reg.end_addr);
            result_reg.status   <= cmd.full_flag;
        end
    end

    // memory address and data select
    always_comb
    begin
        rd_ptr = mid;
        if (cmd.rd_prev)
            rd_ptr = lo_reg - ONE_CNT;
        else if (cmd.rd_shift)
            rd_ptr = idx_reg - ONE_CNT;
    end

    assign rd_en   = cmd.rd_mid || cmd.rd_prev || cmd.rd_shift;
    assign wr_en   = cmd.wr_shift || cmd.wr_ins;
    assign wr_ptr  = cmd.wr_ins ? lo_reg : idx_reg;
    assign wr_data = cmd.wr_ins ? entry_t'{start_addr: key_reg, end_addr: last_reg} : rd_reg;

    // range memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr[IDX_W-1:0]] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_ptr[IDX_W-1:0]];
    end

    assign done   = done_reg;
    assign result = result_reg;

    ap_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    ap_window: assert property (@(posedge clk) disable iff (!rst_n)
        (lo_reg <= hi_reg) && (hi_reg <= CAP_CNT))
        else $error("search window out of order");

    ap_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_ins |-> (count_reg < CAP_CNT) && (lo_reg <= count_reg))
        else $error("insert write with no free slot");

    ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// ===== rtl/core/ip_range_lookup_table.sv =====
// ----------------------------------------------------------------------------
// ip_range_lookup_table
// Sorted IPv4 range table with insert, nearest-left lookup and clear.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and cannot be held off. Every
// word gives one result. Work is paced by the range memory, with one write
// port and one registered read port. A binary search step reads the midpoint
// entry, then narrows the window, for at most ceil(log2(CAPACITY+1)) steps.
// A lookup then reads the entry just left of the search result, if any, and
// compares its end; a clear or a dropped insert goes straight to the result.
// An insert reads and moves up one slot each entry with a start above the
// new one, then writes the new range. busy falls in the cycle done rises, so
// the next word may be taken while the result is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_range_lookup_table #(
    parameter int CAPACITY = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire iprlt_pkg::in_word_t  item,
    output logic                      done,
    output iprlt_pkg::out_word_t      result
);
    import iprlt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    iprlt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // table storage and compare logic
    iprlt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
